### hdl/ipcsum_pkg.sv
// ----------------------------------------------------------------------------
// ipcsum_pkg
// Shared types, constants and ones' complement helpers for the checksum engine.
// ----------------------------------------------------------------------------
package ipcsum_pkg;

    localparam int BYTE_W = 8;
    localparam int WORD_W = 16;
    localparam int ADDR_W = 32;
    // Six 16-bit pseudo-header words sum to less than 2**19.
    localparam int RAW_W  = 19;

    localparam logic [WORD_W-1:0] PROTO_TCP = 16'd6;

    // Checksum kinds selected by op on the first byte of a region.
    localparam logic OP_IP  = 1'b0;
    localparam logic OP_TCP = 1'b1;

    typedef struct packed {
        logic              first;
        logic              last;
        logic [BYTE_W-1:0] data_byte;
        logic [RAW_W-1:0]  pseudo_raw;
    } item_t;

    // 16-bit ones' complement add with end-around carry.
    function automatic logic [WORD_W-1:0] oc_add(logic [WORD_W-1:0] a,
                                                logic [WORD_W-1:0] b);
        logic [WORD_W:0] t;
        t = {1'b0, a} + {1'b0, b};
        return t[WORD_W-1:0] + {{(WORD_W-1){1'b0}}, t[WORD_W]};
    endfunction

    // Folds the unreduced pseudo-header total into 16 bits. A nonzero total
    // never folds to zero, which matches a chain of oc_add steps.
    function automatic logic [WORD_W-1:0] fold_raw(logic [RAW_W-1:0] raw);
        logic [WORD_W:0] t;
        t = {1'b0, raw[WORD_W-1:0]}
            + {{(2*WORD_W-RAW_W+1){1'b0}}, raw[RAW_W-1:WORD_W]};
        return t[WORD_W-1:0] + {{(WORD_W-1){1'b0}}, t[WORD_W]};
    endfunction

endpackage

### hdl/ipcsum_in_if.sv
// ----------------------------------------------------------------------------
// ipcsum_in_if
// Byte channel into the checksum engine, with the pseudo-header fields.
// ----------------------------------------------------------------------------
interface ipcsum_in_if;

    logic                              valid;
    logic                              ready;
    logic                              op;
    logic [ipcsum_pkg::BYTE_W-1:0]     data_byte;
    logic                              first;
    logic                              last;
    logic [ipcsum_pkg::ADDR_W-1:0]     src_addr;
    logic [ipcsum_pkg::ADDR_W-1:0]     dst_addr;
    logic [ipcsum_pkg::WORD_W-1:0]     seg_len;

    modport source (
        output valid, op, data_byte, first, last, src_addr, dst_addr, seg_len,
        input  ready
    );

    modport sink (
        input  valid, op, data_byte, first, last, src_addr, dst_addr, seg_len,
        output ready
    );

endinterface

### hdl/ipcsum_out_if.sv
// ----------------------------------------------------------------------------
// ipcsum_out_if
// Result channel of the checksum engine.
// ----------------------------------------------------------------------------
interface ipcsum_out_if;

    logic                          valid;
    logic                          ready;
    logic [ipcsum_pkg::WORD_W-1:0] checksum;

    modport source (
        output valid, checksum,
        input  ready
    );

    modport sink (
        input  valid, checksum,
        output ready
    );

endinterface

### hdl/ipcsum_in_stage.sv
// ----------------------------------------------------------------------------
// ipcsum_in_stage
// Input register; adds up the pseudo-header words of a first TCP byte.
// ----------------------------------------------------------------------------
module ipcsum_in_stage (
    input  logic              clk,
    input  logic              rst_n,
    ipcsum_in_if.sink         pkt,
    input  logic              advance,
    output logic              s1_valid,
    output ipcsum_pkg::item_t s1_item
);

    logic                          valid_reg;
    logic                          valid_next;
    ipcsum_pkg::item_t             item_reg;
    logic                          accept;
    logic [ipcsum_pkg::RAW_W-1:0]  raw_sum;

    localparam int EXT_W = ipcsum_pkg::RAW_W - ipcsum_pkg::WORD_W;

    assign pkt.ready = !valid_reg || advance;
    assign accept    = pkt.valid && pkt.ready;

    always_comb
    begin
        raw_sum = {{EXT_W{1'b0}}, pkt.src_addr[31:16]}
                + {{EXT_W{1'b0}}, pkt.src_addr[15:0]}
                + {{EXT_W{1'b0}}, pkt.dst_addr[31:16]}
                + {{EXT_W{1'b0}}, pkt.dst_addr[15:0]}
                + {{EXT_W{1'b0}}, ipcsum_pkg::PROTO_TCP}
                + {{EXT_W{1'b0}}, pkt.seg_len};
    end

    always_comb
    begin
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.first      <= pkt.first;
            item_reg.last       <= pkt.last;
            item_reg.data_byte  <= pkt.data_byte;
            // Only a first byte in TCP mode brings a pseudo-header.
            item_reg.pseudo_raw <= (pkt.first && (pkt.op == ipcsum_pkg::OP_TCP)) ? raw_sum
                                                                                 : '0;
        end
    end

    assign s1_valid = valid_reg;
    assign s1_item  = item_reg;

endmodule

### hdl/ipcsum_accum.sv
// ----------------------------------------------------------------------------
// ipcsum_accum
// Running ones' complement sum, byte pairing and the result register.
// ----------------------------------------------------------------------------
module ipcsum_accum (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s1_valid,
    input  ipcsum_pkg::item_t s1_item,
    output logic              advance,
    ipcsum_out_if.source      res
);

    logic [ipcsum_pkg::WORD_W-1:0] sum_reg;
    logic [ipcsum_pkg::WORD_W-1:0] sum_next;
    logic                          odd_reg;
    logic                          odd_next;
    logic [ipcsum_pkg::BYTE_W-1:0] held_reg;
    logic [ipcsum_pkg::WORD_W-1:0] checksum_reg;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic                          out_free;
    logic                          eff_odd;
    logic [ipcsum_pkg::WORD_W-1:0] base;
    logic [ipcsum_pkg::WORD_W-1:0] word;
    logic [ipcsum_pkg::WORD_W-1:0] new_sum;
    logic                          emit;

    assign out_free = !out_valid_reg || res.ready;
    // Bytes that end no region never wait for the result register.
    assign advance  = s1_valid && (!s1_item.last || out_free);
    assign emit     = advance && s1_item.last;

    always_comb
    begin
        // A first mark drops any held byte and restarts from the pseudo-header.
        eff_odd = odd_reg && !s1_item.first;
        base    = s1_item.first ? ipcsum_pkg::fold_raw(s1_item.pseudo_raw) : sum_reg;
        // A lone trailing high byte is padded with a zero low byte.
        word    = eff_odd ? {held_reg, s1_item.data_byte}
                          : {s1_item.data_byte, {ipcsum_pkg::BYTE_W{1'b0}}};
        if (eff_odd || s1_item.last)
        begin
            new_sum = ipcsum_pkg::oc_add(base, word);
        end
        else
        begin
            new_sum = base;
        end
    end

    always_comb
    begin
        sum_next = sum_reg;
        odd_next = odd_reg;
        if (advance)
        begin
            if (s1_item.last)
            begin
                sum_next = '0;
                odd_next = 1'b0;
            end
            else
            begin
                sum_next = new_sum;
                odd_next = !eff_odd;
            end
        end
    end

    always_comb
    begin
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg       <= '0;
            odd_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sum_reg       <= sum_next;
            odd_reg       <= odd_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && !eff_odd)
        begin
            held_reg <= s1_item.data_byte;
        end
        if (emit)
        begin
            checksum_reg <= ~new_sum;
        end
    end

    assign res.valid    = out_valid_reg;
    assign res.checksum = checksum_reg;

`ifndef ASSERT_OFF
    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> (sum_reg == '0) && !odd_reg)
        else $error("state not cleared after the last byte of a region");

    a_last_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid && s1_item.last && out_valid_reg && !res.ready) |-> !advance)
        else $error("last byte advanced while the result register was full");

    a_first_holds_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && s1_item.first && !s1_item.last) |=> odd_reg)
        else $error("first byte of a region not held as a high byte");

    a_result_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !res.ready) |=> $stable(checksum_reg) && out_valid_reg)
        else $error("pending result lost or changed");
`endif

endmodule

### hdl/ip_tcp_checksum_engine_top.sv
// ----------------------------------------------------------------------------
// ip_tcp_checksum_engine_top
// Streaming internet checksum with an optional TCP pseudo-header.
// ----------------------------------------------------------------------------
// Usage: the pkt channel carries one byte of a header or segment per
// transfer, in network order. Mark the opening byte with first; on that
// byte op selects the plain IP checksum (0) or the TCP checksum (1), and in
// TCP mode src_addr, dst_addr and seg_len are taken for the pseudo-header.
// Mark the closing byte with last. The checksum field must be sent as zero.
// The res channel gives one checksum transfer for each last byte.
// Path: a last byte passes the input register, then its checksum the
// result register, from which it is offered on res. Throughput: one byte
// per cycle while no stall (below) holds the input; the running sum loops
// through sum_reg alone. An input and a result register make two stages.
// Stall: while a result waits on res, non-last bytes keep flowing; a further
// last byte waits in the input register, after which pkt.ready falls.
// Reset clears the running sum, the pairing phase and both valid flags.
// ----------------------------------------------------------------------------
module ip_tcp_checksum_engine_top (
    input  logic          clk,
    input  logic          rst_n,
    ipcsum_in_if.sink     pkt,
    ipcsum_out_if.source  res
);

    logic              s1_valid;
    ipcsum_pkg::item_t s1_item;
    logic              advance;

    ipcsum_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .pkt      (pkt),
        .advance  (advance),
        .s1_valid (s1_valid),
        .s1_item  (s1_item)
    );

    ipcsum_accum u_accum (
        .clk      (clk),
        .rst_n    (rst_n),
        .s1_valid (s1_valid),
        .s1_item  (s1_item),
        .advance  (advance),
        .res      (res)
    );

endmodule
